>>> src/keyed_membership_table_assert.svh
// Assertion macros shared by the checker of the membership table.
`ifndef KEYED_MEMBERSHIP_TABLE_ASSERT_SVH
`define KEYED_MEMBERSHIP_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("membership table check failed");

// The consequent must hold in the cycle after the antecedent.
`define KMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("membership table check failed");

`endif

>>> src/kmt_pkg.sv
// Package with the shared types and codes of the membership table.
package kmt_pkg;

  localparam int FUNC_W    = 2;
  localparam int IN_ID_W   = 64;
  localparam int LEN_W     = 4;
  localparam int STATE_W   = 2;
  localparam int EPOCH_W   = 64;
  localparam int OUT_IDX_W = 4;
  localparam int OUT_CNT_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CONFIRM  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 2'd2;

  localparam logic [STATE_W-1:0] MEMBER_NONE   = 2'd0;
  localparam logic [STATE_W-1:0] MEMBER_ACTIVE = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } seq_state_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic start;
    logic need_scan;
    logic row_match;
    logic last_row;
  } seq_stat_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } seq_ctl_t;

endpackage

>>> src/kmt_row_mem.sv
// Row storage of the membership table: one write port, one registered read port.
module kmt_row_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 134
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/kmt_cmp.sv
// Shared compare unit: key equality while scanning, epoch checks when finishing.
module kmt_cmp (
  input  logic [kmt_pkg::EPOCH_W-1:0] a,
  input  logic [kmt_pkg::EPOCH_W-1:0] b,
  input  logic [kmt_pkg::LEN_W-1:0]   a_len,
  input  logic [kmt_pkg::LEN_W-1:0]   b_len,
  output logic                        eq,
  output logic                        gt
);

  assign eq = (a == b) && (a_len == b_len);
  assign gt = (a > b);

endmodule

>>> src/kmt_seq.sv
// Sequencer that walks the used rows one per cycle and then resolves the item.
module kmt_seq #(
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kmt_pkg::seq_stat_t  stat,
  output kmt_pkg::seq_ctl_t   ctl,
  output logic                busy,
  output logic [IDX_W-1:0]    ptr,
  output logic [IDX_W-1:0]    rd_addr
);

  kmt_pkg::seq_state_t state_r, state_nxt;
  logic [IDX_W-1:0]    ptr_r, ptr_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kmt_pkg::ST_IDLE: begin
        if (stat.start) begin
          state_nxt = stat.need_scan ? kmt_pkg::ST_SCAN : kmt_pkg::ST_FINISH;
        end
      end
      kmt_pkg::ST_SCAN: begin
        if (stat.row_match || stat.last_row) begin
          state_nxt = kmt_pkg::ST_FINISH;
        end
      end
      kmt_pkg::ST_FINISH: state_nxt = kmt_pkg::ST_IDLE;
      default:            state_nxt = kmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.accept = (state_r == kmt_pkg::ST_IDLE) && stat.start;
    ctl.scan   = (state_r == kmt_pkg::ST_SCAN);
    ctl.finish = (state_r == kmt_pkg::ST_FINISH);
    busy       = (state_r != kmt_pkg::ST_IDLE);
    // The read port runs one row ahead of the row being compared.
    rd_addr    = (state_r == kmt_pkg::ST_IDLE) ? '0 : ptr_r + IDX_W'(1);
    ptr_nxt    = ptr_r;
    if (ctl.accept) begin
      ptr_nxt = '0;
    end else if (ctl.scan && !stat.row_match && !stat.last_row) begin
      ptr_nxt = ptr_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kmt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
  end

  assign ptr = ptr_r;

endmodule

>>> src/keyed_membership_table.sv
// Keyed membership table: register, confirm and lookup of members by ID.
// After acceptance an item compares N rows, N being 0 to TABLE_DEPTH, one row per
// cycle through the single compare unit and the table memory's registered read
// port; it then resolves and writes back, and the result is registered.
// A new item is accepted only while the block is idle; results cannot be stalled.
// Reset empties the table and clears the site epoch; row contents are not cleared.
module keyed_membership_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_BYTES    = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [kmt_pkg::FUNC_W-1:0]    in_func,
  input  logic [kmt_pkg::IN_ID_W-1:0]   in_id_bytes,
  input  logic [kmt_pkg::LEN_W-1:0]     in_id_length,
  input  logic [kmt_pkg::STATE_W-1:0]   in_member_state,
  input  logic [kmt_pkg::EPOCH_W-1:0]   in_epoch,
  output logic                          out_valid,
  output logic                          out_status,
  output logic                          out_found,
  output logic [kmt_pkg::OUT_IDX_W-1:0] out_row_index,
  output logic [kmt_pkg::STATE_W-1:0]   out_row_state,
  output logic [kmt_pkg::EPOCH_W-1:0]   out_row_epoch,
  output logic [kmt_pkg::EPOCH_W-1:0]   out_site_epoch,
  output logic [kmt_pkg::OUT_CNT_W-1:0] out_member_count
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W  = 8 * ID_BYTES;
  localparam int ROW_W = kmt_pkg::LEN_W + kmt_pkg::STATE_W + kmt_pkg::EPOCH_W + ID_W;

  kmt_pkg::seq_stat_t stat;
  kmt_pkg::seq_ctl_t  ctl;
  logic [IDX_W-1:0]   ptr;
  logic [IDX_W-1:0]   rd_addr;

  // Item registers.
  logic [kmt_pkg::FUNC_W-1:0]  func_r;
  logic [kmt_pkg::IN_ID_W-1:0] key_r;
  logic [kmt_pkg::LEN_W-1:0]   len_r;
  logic [kmt_pkg::STATE_W-1:0] mstate_r;
  logic [kmt_pkg::EPOCH_W-1:0] epoch_r;
  logic                        reg_ok_r;
  logic                        hit_r;
  logic [IDX_W-1:0]            hit_idx_r;
  logic [kmt_pkg::STATE_W-1:0] hit_state_r;
  logic [kmt_pkg::EPOCH_W-1:0] hit_epoch_r;

  // Table state.
  logic [CNT_W-1:0]            rows_used_r, rows_used_nxt;
  logic [kmt_pkg::EPOCH_W-1:0] site_r, site_nxt;

  // Result registers.
  logic                          out_valid_r;
  logic                          status_r, status_nxt;
  logic                          found_r, found_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [kmt_pkg::STATE_W-1:0]   rstate_r, rstate_nxt;
  logic [kmt_pkg::EPOCH_W-1:0]   repoch_r, repoch_nxt;

  logic [kmt_pkg::IN_ID_W-1:0] key_in;
  logic                        len_ok;
  logic                        reg_args_ok;
  logic                        op_scan;

  logic [ROW_W-1:0]            rd_row;
  logic [ROW_W-1:0]            wr_row;
  logic [kmt_pkg::LEN_W-1:0]   row_len;
  logic [kmt_pkg::STATE_W-1:0] row_state;
  logic [kmt_pkg::EPOCH_W-1:0] row_epoch;
  logic [ID_W-1:0]             row_id;

  logic [kmt_pkg::EPOCH_W-1:0] cmp_a, cmp_b;
  logic [kmt_pkg::LEN_W-1:0]   cmp_a_len, cmp_b_len;
  logic                        cmp_eq, cmp_gt;

  logic                        full;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;

  logic [IDX_W+kmt_pkg::OUT_IDX_W-1:0] idx_ext;
  logic [CNT_W+kmt_pkg::OUT_CNT_W-1:0] cnt_ext;

  // Bytes at or beyond the ID length are cleared so that stored keys compare whole.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_in[i*8 +: 8] = (kmt_pkg::LEN_W'(i) < in_id_length) ? in_id_bytes[i*8 +: 8] : 8'h00;
    end
  end

  assign len_ok      = (in_id_length != '0) && (in_id_length <= kmt_pkg::LEN_W'(ID_BYTES));
  assign reg_args_ok = len_ok && (in_epoch != '0) && (in_member_state != kmt_pkg::MEMBER_NONE);

  always_comb begin
    unique case (in_func)
      kmt_pkg::FUNC_REGISTER: op_scan = reg_args_ok;
      kmt_pkg::FUNC_CONFIRM:  op_scan = len_ok;
      kmt_pkg::FUNC_LOOKUP:   op_scan = len_ok;
      default:                op_scan = 1'b0;
    endcase
  end

  assign {row_len, row_state, row_epoch, row_id} = rd_row;

  assign stat.start     = start;
  assign stat.need_scan = op_scan && (rows_used_r != '0);
  assign stat.row_match = cmp_eq;
  assign stat.last_row  = (CNT_W'(ptr) + CNT_W'(1)) >= rows_used_r;

  kmt_seq #(
    .IDX_W (IDX_W)
  ) u_kmt_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy),
    .ptr     (ptr),
    .rd_addr (rd_addr)
  );

  // The compare unit checks keys while scanning and epochs while finishing.
  always_comb begin
    if (ctl.scan) begin
      cmp_a     = key_r;
      cmp_b     = kmt_pkg::EPOCH_W'(row_id);
      cmp_a_len = len_r;
      cmp_b_len = row_len;
    end else begin
      cmp_a     = epoch_r;
      cmp_b     = (func_r == kmt_pkg::FUNC_REGISTER) ? site_r : hit_epoch_r;
      cmp_a_len = '0;
      cmp_b_len = '0;
    end
  end

  kmt_cmp u_kmt_cmp (
    .a     (cmp_a),
    .b     (cmp_b),
    .a_len (cmp_a_len),
    .b_len (cmp_b_len),
    .eq    (cmp_eq),
    .gt    (cmp_gt)
  );

  assign full    = (rows_used_r == CNT_W'(TABLE_DEPTH));
  assign wr_en   = ctl.finish && (func_r == kmt_pkg::FUNC_REGISTER) && reg_ok_r
                   && (hit_r || !full);
  assign wr_addr = hit_r ? hit_idx_r : rows_used_r[IDX_W-1:0];
  assign wr_row  = {len_r, mstate_r, epoch_r, key_r[ID_W-1:0]};

  kmt_row_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W),
    .DATA_W (ROW_W)
  ) u_kmt_row_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_addr (rd_addr),
    .rd_data (rd_row)
  );

  always_comb begin
    rows_used_nxt = rows_used_r + CNT_W'(wr_en && !hit_r);
    site_nxt      = (wr_en && cmp_gt) ? epoch_r : site_r;
    status_nxt    = 1'b1;
    found_nxt     = 1'b0;
    idx_nxt       = '0;
    rstate_nxt    = '0;
    repoch_nxt    = '0;
    unique case (func_r)
      kmt_pkg::FUNC_REGISTER: begin
        if (wr_en) begin
          status_nxt = 1'b0;
          found_nxt  = hit_r;
          idx_nxt    = wr_addr;
          rstate_nxt = mstate_r;
          repoch_nxt = epoch_r;
        end
      end
      kmt_pkg::FUNC_CONFIRM: begin
        if (hit_r) begin
          found_nxt  = 1'b1;
          idx_nxt    = hit_idx_r;
          rstate_nxt = hit_state_r;
          repoch_nxt = hit_epoch_r;
          status_nxt = !((hit_state_r == kmt_pkg::MEMBER_ACTIVE) && cmp_eq);
        end
      end
      kmt_pkg::FUNC_LOOKUP: begin
        if (hit_r) begin
          status_nxt = 1'b0;
          found_nxt  = 1'b1;
          idx_nxt    = hit_idx_r;
          rstate_nxt = hit_state_r;
          repoch_nxt = hit_epoch_r;
        end
      end
      default: begin
        status_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      func_r   <= in_func;
      key_r    <= key_in;
      len_r    <= in_id_length;
      mstate_r <= in_member_state;
      epoch_r  <= in_epoch;
      reg_ok_r <= reg_args_ok;
    end
    if (ctl.accept) begin
      hit_r <= 1'b0;
    end else if (ctl.scan && cmp_eq) begin
      hit_r       <= 1'b1;
      hit_idx_r   <= ptr;
      hit_state_r <= row_state;
      hit_epoch_r <= row_epoch;
    end
    if (ctl.finish) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      idx_r    <= idx_nxt;
      rstate_r <= rstate_nxt;
      repoch_r <= repoch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= '0;
      site_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
      if (ctl.finish) begin
        rows_used_r <= rows_used_nxt;
        site_r      <= site_nxt;
      end
    end
  end

  assign idx_ext = {{kmt_pkg::OUT_IDX_W{1'b0}}, idx_r};
  assign cnt_ext = {{kmt_pkg::OUT_CNT_W{1'b0}}, rows_used_r};

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_found        = found_r;
  assign out_row_index    = idx_ext[kmt_pkg::OUT_IDX_W-1:0];
  assign out_row_state    = rstate_r;
  assign out_row_epoch    = repoch_r;
  assign out_site_epoch   = site_r;
  assign out_member_count = cnt_ext[kmt_pkg::OUT_CNT_W-1:0];

endmodule

>>> src/kmt_checker.sv
// Port-level checker of the membership table and its bind to the top level.
`include "keyed_membership_table_assert.svh"

module kmt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_found,
  input logic                          out_status,
  input logic [kmt_pkg::OUT_CNT_W-1:0] out_member_count
);

  // An accepted item keeps the block busy until its result is resolved.
  `KMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Each item yields a single one-cycle strobe.
  `KMT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  // The result appears after the block has become free again.
  `KMT_ASSERT_SAME(a_result_idle, out_valid, !busy)
  // A found row implies the table holds at least one member.
  `KMT_ASSERT_SAME(a_found_nonempty, out_valid && out_found, out_member_count != '0)
  // A successful item always involves a row, so the table cannot be empty.
  `KMT_ASSERT_SAME(a_ok_nonempty, out_valid && !out_status, out_member_count != '0)

endmodule

bind keyed_membership_table kmt_checker u_kmt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_found        (out_found),
  .out_status       (out_status),
  .out_member_count (out_member_count)
);
